/* src/bank_mapper_with_scanline_irq_macros.svh */
// Assertion macros shared by the mapper checker
`ifndef BANK_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH
`define BANK_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BMSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmsi: implication check failed");

// next-cycle implication, disabled while reset is low
`define BMSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmsi: next-cycle check failed");

`endif

/* src/bmsi_pkg.sv */
// Shared constants, codes and types of the bank mapper
`default_nettype none
package bmsi_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int OFFSET_W   = 21;
    localparam int COUNT_W    = 9;
    localparam int BANK_W     = 8;
    localparam int BANK_REGS  = 8;
    localparam int BANK_IDX_W = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRG   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHR   = 2'd3;

    localparam logic [ADDR_W-1:0] WR_DECODE_MASK = 16'hE001;
    localparam logic [ADDR_W-1:0] WR_BANK_SELECT = 16'h8000;
    localparam logic [ADDR_W-1:0] WR_BANK_DATA   = 16'h8001;
    localparam logic [ADDR_W-1:0] WR_MIRROR      = 16'hA000;
    localparam logic [ADDR_W-1:0] WR_IRQ_LATCH   = 16'hC000;
    localparam logic [ADDR_W-1:0] WR_IRQ_RELOAD  = 16'hC001;
    localparam logic [ADDR_W-1:0] WR_IRQ_DISABLE = 16'hE000;
    localparam logic [ADDR_W-1:0] WR_IRQ_ENABLE  = 16'hE001;

    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 1'd1;

    localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 9'd32;
    localparam logic [COUNT_W-1:0] CHR_COUNT_RESET = 9'd128;

    localparam int PRG_SWAP_BIT   = 6;
    localparam int CHR_INVERT_BIT = 7;

    localparam logic [BANK_IDX_W-1:0] REG_PRG_A = 3'd6;
    localparam logic [BANK_IDX_W-1:0] REG_PRG_B = 3'd7;

    typedef struct packed {
        logic               start;
        logic [BANK_W-1:0]  dividend;
        logic [COUNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] remainder;
    } mod_rsp_t;

endpackage
`default_nettype wire

/* src/bmsi_if.sv */
// Item, result and configuration channel interfaces
`default_nettype none
interface bmsi_item_if;
    import bmsi_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output cmd, output address, output write_data, input ready);
    modport sink   (input valid, input cmd, input address, input write_data, output ready);
endinterface

interface bmsi_result_if;
    import bmsi_pkg::*;
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] rom_offset;
    logic                irq_line;
    logic                hmirror;

    modport source (output valid, output rom_offset, output irq_line,
                    output hmirror, input ready);
    modport sink   (input valid, input rom_offset, input irq_line,
                    input hmirror, output ready);
endinterface

interface bmsi_cfg_if;
    import bmsi_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COUNT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/bmsi_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module bmsi_ram #(
    parameter int WIDTH = bmsi_pkg::BANK_W,
    parameter int DEPTH = bmsi_pkg::BANK_REGS
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* src/bmsi_mod.sv */
// Bit-serial remainder unit: bank number modulo bank count
`default_nettype none
module bmsi_mod (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bmsi_pkg::mod_req_t  req,
    output bmsi_pkg::mod_rsp_t       rsp
);
    import bmsi_pkg::*;

    localparam int STEP_W = $clog2(BANK_W);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [COUNT_W-1:0]  rem_next;
    logic [BANK_W-1:0]   shift_reg;
    logic [COUNT_W-1:0]  divisor_reg;
    logic [COUNT_W:0]    trial;

    // one restoring step: bring in next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, shift_reg[BANK_W-1]};
        if (trial >= {1'b0, divisor_reg})
        begin
            rem_next = COUNT_W'(trial - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = trial[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(BANK_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            shift_reg   <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[BANK_W-2:0], 1'b0};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;
endmodule
`default_nettype wire

/* src/bank_mapper_with_scanline_irq.sv */
// Register writes, ticks and lookups that need no bank register (out of range, fixed
//   bank, or a bank count of 0 or 1) go from EXEC straight to OUT; lookups through a
//   bank register first wait in DIV for the bit-serial remainder unit.
// No new item is taken until the last result is loaded into the output register; the
//   remainder unit works one bit per cycle over 8 bits.
// Reset: all mapper state cleared, bank counts back to 32 and 128, no clearing pass.
`default_nettype none
module bank_mapper_with_scanline_irq (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bmsi_item_if.sink     item,
    bmsi_result_if.source result,
    bmsi_cfg_if.sink      cfg
);
    import bmsi_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]            state_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [DATA_W-1:0]     data_reg;

    logic [COUNT_W-1:0]    prg_count_reg;
    logic [COUNT_W-1:0]    chr_count_reg;

    logic [BANK_W-1:0]     bank_select_reg;
    logic [BANK_REGS-1:0]  written_reg;
    logic                  rd_written_reg;
    logic [7:0]            irq_latch_reg;
    logic [7:0]            irq_counter_reg;
    logic [7:0]            irq_counter_next;
    logic                  reload_reg;
    logic                  irq_en_reg;
    logic                  irq_pend_reg;
    logic                  mirror_reg;

    logic [OFFSET_W-1:0]   offset_reg;
    logic                  out_valid_reg;
    logic [OFFSET_W-1:0]   out_offset_reg;
    logic                  out_irq_reg;
    logic                  out_mirror_reg;

    logic                  accept;
    logic                  out_free;
    logic [BANK_IDX_W-1:0] rd_idx;
    logic [2:0]            in_chr_win;
    logic [BANK_W-1:0]     ram_rdata;
    logic [BANK_W-1:0]     bank_data;
    logic                  ram_we;
    logic [ADDR_W-1:0]     wr_code;

    logic [1:0]            prg_win;
    logic                  prg_swap;
    logic                  prg_fixed;
    logic [COUNT_W-1:0]    prg_fixed_bank;
    logic [2:0]            chr_win;
    logic [BANK_W-1:0]     chr_bank;
    logic [OFFSET_W-1:0]   exec_offset;
    logic [OFFSET_W-1:0]   div_offset;

    mod_req_t              mod_req;
    mod_rsp_t              mod_rsp;

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid      = out_valid_reg;
    assign result.rom_offset = out_offset_reg;
    assign result.irq_line   = out_irq_reg;
    assign result.hmirror    = out_mirror_reg;

    // bank register that the incoming lookup needs
    assign in_chr_win = item.address[12:10] ^ {bank_select_reg[CHR_INVERT_BIT], 2'b00};
    always_comb
    begin
        if (item.cmd == CMD_PRG)
        begin
            rd_idx = (item.address[14:13] == 2'd1) ? REG_PRG_B : REG_PRG_A;
        end
        else if (in_chr_win[2])
        begin
            rd_idx = in_chr_win - 3'd2;
        end
        else
        begin
            rd_idx = {2'b00, in_chr_win[1]};
        end
    end

    assign wr_code = addr_reg & WR_DECODE_MASK;
    assign ram_we  = (state_reg == ST_EXEC) && (cmd_reg == CMD_WRITE)
                     && (wr_code == WR_BANK_DATA);

    bmsi_ram #(
        .WIDTH (BANK_W),
        .DEPTH (BANK_REGS)
    ) u_bank_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bank_select_reg[BANK_IDX_W-1:0]),
        .wdata (data_reg),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // never-written entries read as their reset value
    assign bank_data = rd_written_reg ? ram_rdata : '0;

    assign prg_win        = addr_reg[14:13];
    assign prg_swap       = bank_select_reg[PRG_SWAP_BIT];
    assign prg_fixed      = (prg_win == 2'd3) || ((prg_win == 2'd0) && prg_swap)
                            || ((prg_win == 2'd2) && !prg_swap);
    assign prg_fixed_bank = (prg_win == 2'd3) ? (prg_count_reg - 9'd1)
                                              : (prg_count_reg - 9'd2);
    assign chr_win        = addr_reg[12:10] ^ {bank_select_reg[CHR_INVERT_BIT], 2'b00};
    assign chr_bank       = chr_win[2] ? bank_data : {bank_data[BANK_W-1:1], chr_win[0]};

    // counts of 0 or 1 leave bank 0; fixed banks are already below the count
    always_comb
    begin
        exec_offset      = '0;
        mod_req.start    = 1'b0;
        mod_req.dividend = bank_data;
        mod_req.divisor  = prg_count_reg;
        case (cmd_reg)
            CMD_PRG:
            begin
                if (addr_reg[15])
                begin
                    if (prg_count_reg <= 9'd1)
                    begin
                        exec_offset = {8'd0, addr_reg[12:0]};
                    end
                    else if (prg_fixed)
                    begin
                        exec_offset = {prg_fixed_bank[7:0], addr_reg[12:0]};
                    end
                    else
                    begin
                        mod_req.start = (state_reg == ST_EXEC);
                    end
                end
            end
            CMD_CHR:
            begin
                mod_req.dividend = chr_bank;
                mod_req.divisor  = chr_count_reg;
                if (addr_reg[15:13] == 3'd0)
                begin
                    if (chr_count_reg <= 9'd1)
                    begin
                        exec_offset = {11'd0, addr_reg[9:0]};
                    end
                    else
                    begin
                        mod_req.start = (state_reg == ST_EXEC);
                    end
                end
            end
            default:
            begin
                exec_offset = '0;
            end
        endcase
    end

    bmsi_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign div_offset = (cmd_reg == CMD_PRG)
                        ? {mod_rsp.remainder[7:0], addr_reg[12:0]}
                        : {2'b00, mod_rsp.remainder, addr_reg[9:0]};

    // scanline counter: reload on zero or request, else count down
    assign irq_counter_next = ((irq_counter_reg == 8'd0) || reload_reg)
                              ? irq_latch_reg : irq_counter_reg - 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prg_count_reg   <= PRG_COUNT_RESET;
            chr_count_reg   <= CHR_COUNT_RESET;
            bank_select_reg <= '0;
            written_reg     <= '0;
            irq_latch_reg   <= '0;
            irq_counter_reg <= '0;
            reload_reg      <= 1'b0;
            irq_en_reg      <= 1'b0;
            irq_pend_reg    <= 1'b0;
            mirror_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_PRG_COUNT: prg_count_reg <= cfg.data;
                    CFG_CHR_COUNT: chr_count_reg <= cfg.data;
                    default:       prg_count_reg <= prg_count_reg;
                endcase
            end

            // a new result loaded in the same cycle keeps valid high
            if (out_valid_reg && result.ready && !((state_reg == ST_OUT) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= mod_req.start ? ST_DIV : ST_OUT;
                    if (cmd_reg == CMD_TICK)
                    begin
                        irq_counter_reg <= irq_counter_next;
                        reload_reg      <= 1'b0;
                        if ((irq_counter_next == 8'd0) && irq_en_reg)
                        begin
                            irq_pend_reg <= 1'b1;
                        end
                    end
                    else if (cmd_reg == CMD_WRITE)
                    begin
                        case (wr_code)
                            WR_BANK_SELECT: bank_select_reg <= data_reg;
                            WR_BANK_DATA:
                                written_reg[bank_select_reg[BANK_IDX_W-1:0]] <= 1'b1;
                            WR_MIRROR:      mirror_reg <= data_reg[0];
                            WR_IRQ_LATCH:   irq_latch_reg <= data_reg;
                            WR_IRQ_RELOAD:  reload_reg <= 1'b1;
                            WR_IRQ_DISABLE:
                            begin
                                irq_en_reg   <= 1'b0;
                                irq_pend_reg <= 1'b0;
                            end
                            WR_IRQ_ENABLE:  irq_en_reg <= 1'b1;
                            default:        mirror_reg <= mirror_reg;
                        endcase
                    end
                end
                ST_DIV:
                begin
                    if (mod_rsp.done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= item.cmd;
            addr_reg       <= item.address;
            data_reg       <= item.write_data;
            rd_written_reg <= written_reg[rd_idx];
        end
        if (state_reg == ST_EXEC)
        begin
            offset_reg <= exec_offset;
        end
        else if ((state_reg == ST_DIV) && mod_rsp.done)
        begin
            offset_reg <= div_offset;
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_offset_reg <= offset_reg;
            out_irq_reg    <= irq_pend_reg;
            out_mirror_reg <= mirror_reg;
        end
    end
endmodule
`default_nettype wire

/* src/bmsi_checker.sv */
// Port-level checker for the bank mapper, bound to the top level
`default_nettype none
`include "bank_mapper_with_scanline_irq_macros.svh"
module bmsi_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_ready,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [bmsi_pkg::OFFSET_W-1:0] rom_offset,
    input wire logic                          irq_line,
    input wire logic                          hmirror
);
    import bmsi_pkg::*;

    // one item in flight: taking an item closes the input side
    `BMSI_ASSERT_NXT(a_busy_after_take, clk, rst_n, item_valid && item_ready, !item_ready)

    // a new result only comes out of a busy block
    `BMSI_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(result_valid), !$past(item_ready))

    // stalled result holds
    `BMSI_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(rom_offset) && $stable(irq_line) && $stable(hmirror))
endmodule

bind bank_mapper_with_scanline_irq bmsi_checker u_bmsi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .rom_offset   (result.rom_offset),
    .irq_line     (result.irq_line),
    .hmirror      (result.hmirror)
);
`default_nettype wire

/* sim/bank_mapper_with_scanline_irq_test.sv */
// Self-checking bench for the bank mapper: random item traffic against a behavioral predictor
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq_test;
    import bmsi_pkg::*;

    localparam logic [ADDR_W-1:0] WR_RAM_PROTECT = 16'hA001;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 165;

    typedef struct packed {
        logic [OFFSET_W-1:0] rom_offset;
        logic                irq_line;
        logic                hmirror;
    } mapper_out_t;

    // Mapper state mirror plus the queue of outputs still owed by the block
    class mapper_tracker;
        logic [COUNT_W-1:0] prg_count;
        logic [COUNT_W-1:0] chr_count;
        logic [BANK_W-1:0]  sel;
        logic [BANK_W-1:0]  banks [BANK_REGS];
        logic [BANK_W-1:0]  latch;
        logic [BANK_W-1:0]  counter;
        bit                 reload_due;
        bit                 irq_on;
        bit                 irq_flag;
        bit                 mirror_h;
        mapper_out_t        due_outs [$];
        int                 mismatches;

        function new();
            prg_count  = PRG_COUNT_RESET;
            chr_count  = CHR_COUNT_RESET;
            sel        = '0;
            foreach (banks[i])
                banks[i] = '0;
            latch      = '0;
            counter    = '0;
            reload_due = 1'b0;
            irq_on     = 1'b0;
            irq_flag   = 1'b0;
            mirror_h   = 1'b0;
            mismatches = 0;
        endfunction

        function void note_count(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
            if (idx == CFG_PRG_COUNT)
                prg_count = val;
            else if (idx == CFG_CHR_COUNT)
                chr_count = val;
        endfunction

        // reduce modulo count, negatives wrap upward; zero count maps to bank 0
        function int wrap_bank(int bank, int count);
            int r;
            if (count == 0)
                return 0;
            r = bank % count;
            if (r < 0)
                r += count;
            return r;
        endfunction

        function logic [OFFSET_W-1:0] prg_lookup(logic [ADDR_W-1:0] a);
            int last;
            int second;
            int bank;
            last   = int'(prg_count) - 1;
            second = int'(prg_count) - 2;
            if (!a[15])
                return '0;
            case (a[14:13])
                2'd0:    bank = sel[PRG_SWAP_BIT] ? second : int'(banks[REG_PRG_A]);
                2'd1:    bank = int'(banks[REG_PRG_B]);
                2'd2:    bank = sel[PRG_SWAP_BIT] ? int'(banks[REG_PRG_A]) : second;
                default: bank = last;
            endcase
            return OFFSET_W'(wrap_bank(bank, int'(prg_count)) * 8192 + a[12:0]);
        endfunction

        function logic [OFFSET_W-1:0] chr_lookup(logic [ADDR_W-1:0] a);
            logic [2:0] win;
            int         bank;
            if (a[15:13] != 3'b000)
                return '0;
            win = a[12:10];
            if (sel[CHR_INVERT_BIT])
                win ^= 3'd4;
            // low half: 2K pairs from R0/R1, high half: 1K windows R2..R5
            if (!win[2])
                bank = int'(banks[{2'b00, win[1]}] & 8'hFE) + win[0];
            else
                bank = int'(banks[win - 3'd2]);
            return OFFSET_W'(wrap_bank(bank, int'(chr_count)) * 1024 + a[9:0]);
        endfunction

        function void apply_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
            case (a & WR_DECODE_MASK)
                WR_BANK_SELECT: sel = d;
                WR_BANK_DATA:   banks[sel[BANK_IDX_W-1:0]] = d;
                WR_MIRROR:      mirror_h = d[0];
                WR_IRQ_LATCH:   latch = d;
                WR_IRQ_RELOAD:  reload_due = 1'b1;
                WR_IRQ_DISABLE:
                begin
                    irq_on   = 1'b0;
                    irq_flag = 1'b0;
                end
                WR_IRQ_ENABLE:  irq_on = 1'b1;
                default: ;
            endcase
        endfunction

        function void scanline();
            if (counter == '0 || reload_due)
            begin
                counter    = latch;
                reload_due = 1'b0;
            end
            else
            begin
                counter = counter - 8'd1;
            end
            if (counter == '0 && irq_on)
                irq_flag = 1'b1;
        endfunction

        function void note_item(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                                logic [DATA_W-1:0] d);
            mapper_out_t o;
            o.rom_offset = '0;
            case (c)
                CMD_WRITE: apply_write(a, d);
                CMD_TICK:  scanline();
                CMD_PRG:   o.rom_offset = prg_lookup(a);
                default:   o.rom_offset = chr_lookup(a);
            endcase
            o.irq_line = irq_flag;
            o.hmirror  = mirror_h;
            due_outs.push_back(o);
        endfunction

        task report(string what, int exp, int got);
            $display("%0t ns mismatch: %s expected 'h%0h got 'h%0h", $time, what, exp, got);
            mismatches++;
        endtask

        task check_result(mapper_out_t got);
            mapper_out_t exp;
            if (due_outs.size() == 0)
            begin
                report("result with no item waiting, rom_offset", 0, got.rom_offset);
                return;
            end
            exp = due_outs.pop_front();
            if (got.rom_offset !== exp.rom_offset)
                report("rom_offset", exp.rom_offset, got.rom_offset);
            if (got.irq_line !== exp.irq_line)
                report("irq_line", exp.irq_line, got.irq_line);
            if (got.hmirror !== exp.hmirror)
                report("hmirror", exp.hmirror, got.hmirror);
        endtask

        function int pending();
            return due_outs.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   items_taken;
    int   tx_pct;
    int   rx_pct;

    mapper_tracker mapper = new();

    bmsi_item_if   item_bus ();
    bmsi_result_if res_bus ();
    bmsi_cfg_if    cfg_bus ();

    bank_mapper_with_scanline_irq u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver stalls in rx_pct cycles of a hundred
    always @(negedge clk)
    begin
        res_bus.ready <= ($urandom_range(99) >= rx_pct);
    end

    always @(posedge clk)
    begin
        mapper_out_t seen;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                mapper.note_count(cfg_bus.index, cfg_bus.data);
            if (item_bus.valid && item_bus.ready)
                mapper.note_item(item_bus.cmd, item_bus.address, item_bus.write_data);
            if (res_bus.valid && res_bus.ready)
            begin
                seen.rom_offset = res_bus.rom_offset;
                seen.irq_line   = res_bus.irq_line;
                seen.hmirror    = res_bus.hmirror;
                mapper.check_result(seen);
            end
        end
    end

    function automatic logic [ADDR_W-1:0] decode_addr(logic [ADDR_W-1:0] base);
        return base | (16'($urandom) & 16'h1FFE);
    endfunction

    task automatic push_item(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d);
        @(negedge clk);
        // sender idles cycle by cycle in tx_pct cycles of a hundred
        while ($urandom_range(99) < tx_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.cmd        <= c;
        item_bus.address    <= a;
        item_bus.write_data <= d;
        do
            @(posedge clk);
        while (!item_bus.ready);
        // ignored writes don't count toward the item budget
        if (!(c == CMD_WRITE && (!a[15] || (a & WR_DECODE_MASK) == WR_RAM_PROTECT)))
            items_taken++;
    endtask

    task automatic write_count(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (mapper.pending() != 0)
            @(negedge clk);
    endtask

    task automatic lookup_item();
        logic [ADDR_W-1:0] a;
        a = 16'($urandom);
        if ($urandom_range(1) == 1)
        begin
            if ($urandom_range(9) != 0)
                a[15] = 1'b1;
            push_item(CMD_PRG, a, 8'($urandom));
        end
        else
        begin
            if ($urandom_range(9) != 0)
                a[15:13] = 3'b000;
            push_item(CMD_CHR, a, 8'($urandom));
        end
    endtask

    task automatic random_burst();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            // latch, reload, enable in most bursts, then count scanlines down toward the interrupt
            push_item(CMD_WRITE, decode_addr(WR_IRQ_LATCH),
                      ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(6)));
            push_item(CMD_WRITE, decode_addr(WR_IRQ_RELOAD), 8'($urandom));
            if ($urandom_range(3) != 0)
                push_item(CMD_WRITE, decode_addr(WR_IRQ_ENABLE), 8'($urandom));
            n = $urandom_range(10, 1);
            repeat (n)
            begin
                push_item(CMD_TICK, 16'($urandom), 8'($urandom));
                if ($urandom_range(3) == 0)
                    lookup_item();
            end
            if ($urandom_range(1) == 1)
                push_item(CMD_WRITE, decode_addr(WR_IRQ_DISABLE), 8'($urandom));
        end
        else if (pick < 45)
        begin
            push_item(CMD_WRITE, decode_addr(WR_BANK_SELECT), 8'($urandom));
            push_item(CMD_WRITE, decode_addr(WR_BANK_DATA), 8'($urandom));
            repeat ($urandom_range(3, 1))
                lookup_item();
        end
        else if (pick < 52)
        begin
            push_item(CMD_WRITE, decode_addr(($urandom_range(3) == 0) ? WR_RAM_PROTECT : WR_MIRROR),
                      8'($urandom));
            lookup_item();
        end
        else if (pick < 88)
        begin
            if ($urandom_range(2) == 0)
                push_item(CMD_TICK, 16'($urandom), 8'($urandom));
            else
                lookup_item();
        end
        else
        begin
            push_item(2'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        logic [COUNT_W-1:0] prg_sets [PHASES];
        logic [COUNT_W-1:0] chr_sets [PHASES];
        int                 target;

        rst_n               = 1'b0;
        items_taken         = 0;
        tx_pct              = 34;
        rx_pct              = 65;
        item_bus.valid      = 1'b0;
        item_bus.cmd        = CMD_WRITE;
        item_bus.address    = '0;
        item_bus.write_data = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_PRG_COUNT;
        cfg_bus.data        = '0;
        res_bus.ready       = 1'b0;

        // phase 0 runs on reset counts; zero count and counts past 256 come late
        prg_sets = '{9'd32, 9'd2, 9'd256, 9'($urandom_range(256, 2)), 9'd0, 9'd511};
        chr_sets = '{9'd128, 9'd8, 9'd256, 9'($urandom_range(256, 8)), 9'd511, 9'd1};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset-state lookups and out-of-range addresses
        push_item(CMD_PRG, 16'hFFFF, 8'h00);
        push_item(CMD_PRG, 16'h7FFF, 8'hFF);
        push_item(CMD_CHR, 16'h0000, 8'h00);
        push_item(CMD_CHR, 16'hFFFF, 8'hFF);
        // load PRG banks and a CHR pair
        push_item(CMD_WRITE, WR_BANK_SELECT, 8'h06);
        push_item(CMD_WRITE, WR_BANK_DATA, 8'hFF);
        push_item(CMD_WRITE, WR_BANK_SELECT, 8'h07);
        push_item(CMD_WRITE, WR_BANK_DATA, 8'h81);
        push_item(CMD_WRITE, WR_BANK_SELECT, 8'h01);
        push_item(CMD_WRITE, WR_BANK_DATA, 8'hFF);
        push_item(CMD_PRG, 16'h8000, 8'h00);
        push_item(CMD_PRG, 16'hA000, 8'h00);
        push_item(CMD_PRG, 16'hC000, 8'h00);
        push_item(CMD_PRG, 16'hE000, 8'h00);
        // PRG swap and CHR inversion together
        push_item(CMD_WRITE, WR_BANK_SELECT, 8'hC0);
        push_item(CMD_PRG, 16'h9FFF, 8'h00);
        push_item(CMD_CHR, 16'h0000, 8'h00);
        push_item(CMD_CHR, 16'h1FFF, 8'h00);
        // mirroring, ignored RAM protect, ignored write below the register space
        push_item(CMD_WRITE, WR_MIRROR, 8'h01);
        push_item(CMD_WRITE, WR_RAM_PROTECT, 8'hFF);
        push_item(CMD_WRITE, 16'h7FFF, 8'hFF);
        // zero latch fires on the first scanline, then acknowledge
        push_item(CMD_WRITE, WR_IRQ_LATCH, 8'h00);
        push_item(CMD_WRITE, WR_IRQ_RELOAD, 8'h00);
        push_item(CMD_WRITE, WR_IRQ_ENABLE, 8'h00);
        push_item(CMD_TICK, 16'h0000, 8'h00);
        push_item(CMD_WRITE, WR_IRQ_DISABLE, 8'h00);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 2)
            begin
                tx_pct = 34;
                rx_pct = 65;
            end
            else if (ph < 4)
            begin
                tx_pct = 65;
                rx_pct = 34;
            end
            else
            begin
                tx_pct = 0;
                rx_pct = 0;
            end
            if (ph > 0)
            begin
                drain();
                write_count(CFG_PRG_COUNT, prg_sets[ph]);
                write_count(CFG_CHR_COUNT, chr_sets[ph]);
            end
            target = items_taken + ITEMS_PER_PHASE;
            while (items_taken < target)
                random_burst();
        end

        drain();
        repeat (20) @(negedge clk);
        if (mapper.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
